@@ sv/qte_pkg.sv @@
package qte_pkg;

  localparam int QW = 32;
  localparam int PW = 34;
  localparam int SW = 36;
  localparam int CW = 40;
  localparam int AW = 34;
  localparam int ANG_W = 16;
  localparam int NW = 62;
  localparam int ROOT_W = 31;
  localparam int SQRT_STEPS = 31;
  localparam int SQRT_LAT = SQRT_STEPS + 2;
  localparam int ATAN_ENTRIES = 24;
  localparam int CFG_AW = 2;

  localparam logic signed [AW-1:0] HALF_PI_ACC = 34'sd1073702875;
  localparam logic signed [QW-1:0] Q30_ONE = 32'sd1073741824;
  localparam logic [NW-1:0] Q60_ONE = 62'h1000_0000_0000_0000;

  localparam logic [CFG_AW-1:0] REG_ROLL_OFFSET = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PITCH_OFFSET = 2'd1;
  localparam logic [CFG_AW-1:0] REG_YAW_OFFSET = 2'd2;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] roll_angle;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] yaw_angle;
  } angles_t;

  function automatic logic signed [AW-1:0] atan_entry(input int unsigned i);
    logic signed [AW-1:0] v;
    case (i)
      0: v = 34'sd536851438;
      1: v = 34'sd316921929;
      2: v = 34'sd167452833;
      3: v = 34'sd85001673;
      4: v = 34'sd42665783;
      5: v = 34'sd21353691;
      6: v = 34'sd10679451;
      7: v = 34'sd5340051;
      8: v = 34'sd2670066;
      9: v = 34'sd1335038;
      10: v = 34'sd667520;
      11: v = 34'sd333760;
      12: v = 34'sd166880;
      13: v = 34'sd83440;
      14: v = 34'sd41720;
      15: v = 34'sd20860;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2607;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/qte_prod.sv @@
module qte_prod (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                vin,
  input  qte_pkg::quat_t                      quat,
  output logic                                vout,
  output logic signed [qte_pkg::SW-1:0]       ry,
  output logic signed [qte_pkg::SW-1:0]       rx,
  output logic signed [qte_pkg::SW-1:0]       yy,
  output logic signed [qte_pkg::SW-1:0]       yx,
  output logic signed [qte_pkg::QW-1:0]       s
);

  localparam int PW = qte_pkg::PW;
  localparam int SW = qte_pkg::SW;

  logic v1;
  logic signed [PW-1:0] ww, aa, bb, cc, bc, wa, ab, wc, ac, wb;
  logic signed [63:0] p_ww, p_aa, p_bb, p_cc, p_bc, p_wa, p_ab, p_wc, p_ac, p_wb;
  logic signed [SW-1:0] s_wide;

  assign p_ww = 64'(quat.quat_w) * 64'(quat.quat_w);
  assign p_aa = 64'(quat.quat_x) * 64'(quat.quat_x);
  assign p_bb = 64'(quat.quat_y) * 64'(quat.quat_y);
  assign p_cc = 64'(quat.quat_z) * 64'(quat.quat_z);
  assign p_bc = 64'(quat.quat_y) * 64'(quat.quat_z);
  assign p_wa = 64'(quat.quat_w) * 64'(quat.quat_x);
  assign p_ab = 64'(quat.quat_x) * 64'(quat.quat_y);
  assign p_wc = 64'(quat.quat_w) * 64'(quat.quat_z);
  assign p_ac = 64'(quat.quat_x) * 64'(quat.quat_z);
  assign p_wb = 64'(quat.quat_w) * 64'(quat.quat_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= vin;
    end
  end

  always_ff @(posedge clk) begin
    ww <= p_ww[63:30];
    aa <= p_aa[63:30];
    bb <= p_bb[63:30];
    cc <= p_cc[63:30];
    bc <= p_bc[63:30];
    wa <= p_wa[63:30];
    ab <= p_ab[63:30];
    wc <= p_wc[63:30];
    ac <= p_ac[63:30];
    wb <= p_wb[63:30];
  end

  assign s_wide = (SW'(ac) - SW'(wb)) <<< 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else begin
      vout <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ry <= (SW'(bc) + SW'(wa)) <<< 1;
    rx <= SW'(ww) - SW'(aa) - SW'(bb) + SW'(cc);
    yy <= (SW'(ab) + SW'(wc)) <<< 1;
    yx <= SW'(ww) + SW'(aa) - SW'(bb) - SW'(cc);
    if (s_wide > SW'(qte_pkg::Q30_ONE)) begin
      s <= qte_pkg::Q30_ONE;
    end else if (s_wide < -SW'(qte_pkg::Q30_ONE)) begin
      s <= -qte_pkg::Q30_ONE;
    end else begin
      s <= s_wide[qte_pkg::QW-1:0];
    end
  end

endmodule

@@ sv/qte_isqrt.sv @@
module qte_isqrt (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 vin,
  input  logic signed [qte_pkg::QW-1:0]        s,
  output logic                                 vout,
  output logic [qte_pkg::ROOT_W-1:0]           root
);

  localparam int NW = qte_pkg::NW;
  localparam int STEPS = qte_pkg::SQRT_STEPS;

  logic va;
  logic [NW-1:0] sq;
  logic signed [63:0] p_sq;
  logic [NW-1:0] n [0:STEPS];
  logic [NW-1:0] r [0:STEPS];
  logic v [0:STEPS];

  assign p_sq = 64'(s) * 64'(s);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      v[0] <= 1'b0;
    end else begin
      va <= vin;
      v[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    sq <= p_sq[NW-1:0];
    n[0] <= qte_pkg::Q60_ONE - sq;
    r[0] <= '0;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [NW-1:0] BITV = NW'(1) << (2 * (STEPS - 1 - k));
    logic [NW-1:0] sum;
    assign sum = r[k] + BITV;
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (n[k] >= sum) begin
        n[k+1] <= n[k] - sum;
        r[k+1] <= (r[k] >> 1) + BITV;
      end else begin
        n[k+1] <= n[k];
        r[k+1] <= r[k] >> 1;
      end
    end
  end

  assign vout = v[STEPS];
  assign root = r[STEPS][qte_pkg::ROOT_W-1:0];

endmodule

@@ sv/qte_cordic.sv @@
module qte_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  vin,
  input  logic signed [qte_pkg::CW-1:0]         x,
  input  logic signed [qte_pkg::CW-1:0]         y,
  output logic                                  vout,
  output logic signed [qte_pkg::ANG_W-1:0]      angle
);

  localparam int CW = qte_pkg::CW;
  localparam int AW = qte_pkg::AW;

  logic signed [CW-1:0] xs [0:STAGES];
  logic signed [CW-1:0] ys [0:STAGES];
  logic signed [AW-1:0] as [0:STAGES];
  logic zs [0:STAGES];
  logic vs [0:STAGES];
  logic [AW-1:0] mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= vin;
    end
  end

  always_ff @(posedge clk) begin
    zs[0] <= (x == '0) && (y == '0);
    if (x[CW-1] && !y[CW-1]) begin
      xs[0] <= y;
      ys[0] <= -x;
      as[0] <= qte_pkg::HALF_PI_ACC;
    end else if (x[CW-1]) begin
      xs[0] <= -y;
      ys[0] <= x;
      as[0] <= -qte_pkg::HALF_PI_ACC;
    end else begin
      xs[0] <= x;
      ys[0] <= y;
      as[0] <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = qte_pkg::atan_entry(i);
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs[i];
      end
    end
    always_ff @(posedge clk) begin
      zs[i+1] <= zs[i];
      if (!ys[i][CW-1]) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        as[i+1] <= as[i] + ATAN;
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        as[i+1] <= as[i] - ATAN;
      end
    end
  end

  assign mag = as[STAGES][AW-1] ? AW'(-as[STAGES]) : as[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else begin
      vout <= vs[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (zs[STAGES]) begin
      angle <= '0;
    end else if (as[STAGES][AW-1]) begin
      angle <= -mag[qte_pkg::ANG_W+15:16];
    end else begin
      angle <= mag[qte_pkg::ANG_W+15:16];
    end
  end

endmodule

@@ sv/quaternion_to_euler_angles_core.sv @@
// Quaternion to ZYX Euler angles. Takes one Q30 quaternion word per cycle on start
// (busy is always low) and returns roll, pitch and yaw, 10430 counts per radian, less
// the configured offsets, on angles with a one-cycle done strobe. The pipeline runs
// the component products and sums, then the bit-per-stage square root behind the
// pitch cosine, then the unrolled vectoring CORDIC, and last the offset subtract.
// done cannot be held off.
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  qte_pkg::quat_t                        quat,
  output logic                                  done,
  output qte_pkg::angles_t                      angles,
  input  logic                                  cfg_en,
  input  logic [qte_pkg::CFG_AW-1:0]            cfg_addr,
  input  logic [qte_pkg::ANG_W-1:0]             cfg_data
);

  localparam int SW = qte_pkg::SW;
  localparam int CW = qte_pkg::CW;
  localparam int QW = qte_pkg::QW;
  localparam int LAT = qte_pkg::SQRT_LAT;

  logic p_v;
  logic signed [SW-1:0] p_ry, p_rx, p_yy, p_yx;
  logic signed [QW-1:0] p_s;
  logic sq_v;
  logic [qte_pkg::ROOT_W-1:0] sq_root;
  logic signed [SW-1:0] d_ry [0:LAT-1];
  logic signed [SW-1:0] d_rx [0:LAT-1];
  logic signed [SW-1:0] d_yy [0:LAT-1];
  logic signed [SW-1:0] d_yx [0:LAT-1];
  logic signed [QW-1:0] d_s [0:LAT-1];
  logic roll_v, pitch_v, yaw_v;
  logic signed [qte_pkg::ANG_W-1:0] roll_a, pitch_a, yaw_a;
  logic [qte_pkg::ANG_W-1:0] roll_off, pitch_off, yaw_off;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_off <= '0;
      pitch_off <= '0;
      yaw_off <= '0;
    end else if (cfg_en) begin
      case (cfg_addr)
        qte_pkg::REG_ROLL_OFFSET: roll_off <= cfg_data;
        qte_pkg::REG_PITCH_OFFSET: pitch_off <= cfg_data;
        qte_pkg::REG_YAW_OFFSET: yaw_off <= cfg_data;
        default: ;
      endcase
    end
  end

  qte_prod u_prod (
    .clk  (clk),
    .rst  (rst),
    .vin  (start && !busy),
    .quat (quat),
    .vout (p_v),
    .ry   (p_ry),
    .rx   (p_rx),
    .yy   (p_yy),
    .yx   (p_yx),
    .s    (p_s)
  );

  qte_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .vin  (p_v),
    .s    (p_s),
    .vout (sq_v),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    d_ry[0] <= p_ry;
    d_rx[0] <= p_rx;
    d_yy[0] <= p_yy;
    d_yx[0] <= p_yx;
    d_s[0] <= p_s;
  end

  for (genvar k = 1; k < LAT; k++) begin : g_delay
    always_ff @(posedge clk) begin
      d_ry[k] <= d_ry[k-1];
      d_rx[k] <= d_rx[k-1];
      d_yy[k] <= d_yy[k-1];
      d_yx[k] <= d_yx[k-1];
      d_s[k] <= d_s[k-1];
    end
  end

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk   (clk),
    .rst   (rst),
    .vin   (sq_v),
    .x     (CW'(d_rx[LAT-1])),
    .y     (CW'(d_ry[LAT-1])),
    .vout  (roll_v),
    .angle (roll_a)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk   (clk),
    .rst   (rst),
    .vin   (sq_v),
    .x     (CW'({1'b0, sq_root})),
    .y     (CW'(d_s[LAT-1])),
    .vout  (pitch_v),
    .angle (pitch_a)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk   (clk),
    .rst   (rst),
    .vin   (sq_v),
    .x     (CW'(d_yx[LAT-1])),
    .y     (CW'(d_yy[LAT-1])),
    .vout  (yaw_v),
    .angle (yaw_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= roll_v;
    end
  end

  always_ff @(posedge clk) begin
    angles.roll_angle <= roll_a - roll_off;
    angles.pitch_angle <= pitch_a - pitch_off;
    angles.yaw_angle <= yaw_a - yaw_off;
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (roll_v == pitch_v) && (roll_v == yaw_v))
    else $error("angle lanes out of step");

  a_pitch_sat: assert property (@(posedge clk) disable iff (rst)
    p_v |-> (p_s <= qte_pkg::Q30_ONE) && (p_s >= -qte_pkg::Q30_ONE))
    else $error("pitch argument not saturated");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    sq_v |-> (sq_root <= qte_pkg::ROOT_W'(qte_pkg::Q30_ONE)))
    else $error("cosine above one");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    roll_v |=> done)
    else $error("result strobe lost");

endmodule
